/* rtl/core/ncc_pkg.sv */
// Shared types and constants for the nearest color classifier.
package ncc_pkg;

  localparam int RATIO_W = 16;
  localparam int SUM_W   = 18;
  localparam int TAG_W   = 4;
  localparam int WT_W    = 10;
  localparam int SQ_W    = 2 * RATIO_W;
  localparam int WPROD_W = WT_W + SQ_W;
  localparam int GB_W    = SQ_W + 1;
  localparam int DIST_W  = WPROD_W - 8 + 1;
  localparam int ENTRY_W = 3 * RATIO_W;

  localparam logic MODE_STORE    = 1'b0;
  localparam logic MODE_CLASSIFY = 1'b1;

  localparam logic            REG_RED_WEIGHT = 1'b0;
  localparam logic [WT_W-1:0] RED_WEIGHT_RST = 10'd307;

  typedef struct packed {
    logic               mode;
    logic               side;
    logic [TAG_W-1:0]   color_index;
    logic [RATIO_W-1:0] red;
    logic [RATIO_W-1:0] green;
    logic [RATIO_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0] class_index;
    logic             is_classification;
  } out_item_t;

  typedef struct packed {
    logic               mode;
    logic               side;
    logic [TAG_W-1:0]   color_index;
    logic [RATIO_W-1:0] ratio_r;
    logic [RATIO_W-1:0] ratio_g;
    logic [RATIO_W-1:0] ratio_b;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

/* rtl/core/ncc_ram.sv */
// Generic single write, single read RAM with registered read data.
module ncc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ncc_front.sv */
// Front end: accepts items and converts raw counts to chromaticity ratios.
module ncc_front import ncc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  in_item_t item_i,
  output logic     busy_o,
  output q_push_t  push_o,
  input  logic     full_i
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} state_e;

  state_e             state_q;
  logic [3:0]         cnt_q;
  logic               mode_q;
  logic               side_q;
  logic [TAG_W-1:0]   idx_q;
  logic [SUM_W-1:0]   sum_q;
  logic               zero_q;
  logic [SUM_W-1:0]   rem_q [3];
  logic [RATIO_W-1:0] quo_q [3];
  logic [SUM_W-1:0]   rem_d [3];
  logic [RATIO_W-1:0] quo_d [3];
  logic [SUM_W-1:0]   sum_d;
  logic               accept;

  assign accept = start_i && (state_q == F_IDLE);
  assign busy_o = (state_q != F_IDLE);
  assign sum_d  = SUM_W'(item_i.red) + SUM_W'(item_i.green) + SUM_W'(item_i.blue);

  always_comb begin
    logic [SUM_W:0] trial;
    logic           ge;
    for (int k = 0; k < 3; k++) begin
      trial    = {rem_q[k], 1'b0};
      ge       = (trial >= {1'b0, sum_q});
      rem_d[k] = ge ? SUM_W'(trial - {1'b0, sum_q}) : SUM_W'(trial);
      quo_d[k] = {quo_q[k][RATIO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (start_i) begin
            state_q <= F_DIV;
            cnt_q   <= '0;
          end
        end
        F_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'(RATIO_W - 1)) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= item_i.mode;
      side_q   <= item_i.side;
      idx_q    <= item_i.color_index;
      sum_q    <= sum_d;
      zero_q   <= (sum_d == '0);
      rem_q[0] <= SUM_W'(item_i.red);
      rem_q[1] <= SUM_W'(item_i.green);
      rem_q[2] <= SUM_W'(item_i.blue);
    end else if (state_q == F_DIV) begin
      for (int k = 0; k < 3; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  // part == sum keeps the remainder at sum, so every quotient bit is set: saturation
  always_comb begin
    push_o.valid             = (state_q == F_PUSH) && !full_i;
    push_o.entry.mode        = mode_q;
    push_o.entry.side        = side_q;
    push_o.entry.color_index = idx_q;
    push_o.entry.ratio_r     = zero_q ? '0 : quo_q[0];
    push_o.entry.ratio_g     = zero_q ? '0 : quo_q[1];
    push_o.entry.ratio_b     = zero_q ? '0 : quo_q[2];
  end

endmodule

/* rtl/core/ncc_fifo.sv */
// Two-entry queue between the front end and the table engine.
module ncc_fifo import ncc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_push_t push_i,
  output logic    full_o,
  output q_head_t head_o,
  input  logic    pop_i
);

  q_entry_t   mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.entry = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i.valid && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i.valid) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

/* rtl/core/ncc_back.sv */
// Table engine: stores reference entries and scans one side for the nearest one.
module ncc_back import ncc_pkg::*; #(
  parameter int NUM_COLORS = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  q_head_t         head_i,
  output logic            pop_o,
  input  logic [WT_W-1:0] red_weight_i,
  output logic            result_valid_o,
  output out_item_t       result_o
);

  localparam int DEPTH = 2 * NUM_COLORS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(NUM_COLORS);
  localparam int CW    = TAG_W + 1;
  localparam logic [IW-1:0] LAST = IW'(NUM_COLORS - 1);

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_WAIT} state_e;

  state_e             state_q;
  logic [IW-1:0]      cnt_q;
  logic [AW-1:0]      base_q;
  logic [RATIO_W-1:0] s_r_q, s_g_q, s_b_q;
  logic               valid_q [DEPTH];
  logic [DIST_W-1:0]  best_q;
  logic [TAG_W-1:0]   best_tag_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic               p1_v_q, p2_v_q, p3_v_q;
  logic [IW-1:0]      p1_idx_q, p2_idx_q, p3_idx_q;
  logic               p1_hit_q;
  logic [TAG_W-1:0]   p2_tag_q, p3_tag_q;
  logic [SQ_W-1:0]    sq_r_q, sq_g_q, sq_b_q;
  logic [WPROD_W-1:0] wr_q;
  logic [GB_W-1:0]    gb_q;

  logic               store_go, in_range, wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr, side_base;
  logic [ENTRY_W-1:0] rdata;
  logic [RATIO_W-1:0] e_r, e_g, e_b, d_r, d_g, d_b;
  logic [DIST_W-1:0]  dist_sum;
  logic               take, last;

  assign pop_o     = (state_q == B_IDLE) && head_i.valid;
  assign store_go  = pop_o && (head_i.entry.mode == MODE_STORE);
  assign in_range  = ({1'b0, head_i.entry.color_index} < CW'(NUM_COLORS));
  assign side_base = head_i.entry.side ? AW'(NUM_COLORS) : '0;
  assign wr_en     = store_go && in_range;
  assign wr_addr   = side_base + AW'(head_i.entry.color_index);
  assign rd_en     = (state_q == B_SCAN);
  assign rd_addr   = base_q + AW'(cnt_q);

  ncc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i({head_i.entry.ratio_r, head_i.entry.ratio_g, head_i.entry.ratio_b}),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  // unwritten entries read as zero ratios with tag 0
  assign e_r = p1_hit_q ? rdata[3*RATIO_W-1:2*RATIO_W] : '0;
  assign e_g = p1_hit_q ? rdata[2*RATIO_W-1:RATIO_W]   : '0;
  assign e_b = p1_hit_q ? rdata[RATIO_W-1:0]           : '0;
  assign d_r = (s_r_q >= e_r) ? (s_r_q - e_r) : (e_r - s_r_q);
  assign d_g = (s_g_q >= e_g) ? (s_g_q - e_g) : (e_g - s_g_q);
  assign d_b = (s_b_q >= e_b) ? (s_b_q - e_b) : (e_b - s_b_q);

  assign dist_sum = DIST_W'(wr_q[WPROD_W-1:8]) + DIST_W'(gb_q);
  assign take     = p3_v_q && ((p3_idx_q == '0) || (dist_sum < best_q));
  assign last     = p3_v_q && (p3_idx_q == LAST);

  always_ff @(posedge clk_i) begin
    sq_r_q   <= SQ_W'(d_r) * SQ_W'(d_r);
    sq_g_q   <= SQ_W'(d_g) * SQ_W'(d_g);
    sq_b_q   <= SQ_W'(d_b) * SQ_W'(d_b);
    p2_idx_q <= p1_idx_q;
    p2_tag_q <= p1_hit_q ? TAG_W'(p1_idx_q) : '0;
    wr_q     <= WPROD_W'(red_weight_i) * WPROD_W'(sq_r_q);
    gb_q     <= GB_W'(sq_g_q) + GB_W'(sq_b_q);
    p3_idx_q <= p2_idx_q;
    p3_tag_q <= p2_tag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      base_q      <= '0;
      s_r_q       <= '0;
      s_g_q       <= '0;
      s_b_q       <= '0;
      best_q      <= '0;
      best_tag_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      p3_v_q      <= 1'b0;
      p1_idx_q    <= '0;
      p1_hit_q    <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      out_valid_q <= store_go || last;
      p1_v_q      <= rd_en;
      p2_v_q      <= p1_v_q;
      p3_v_q      <= p2_v_q;
      if (rd_en) begin
        p1_idx_q <= cnt_q;
        p1_hit_q <= valid_q[rd_addr];
      end
      case (state_q)
        B_IDLE: begin
          if (store_go) begin
            out_q       <= '{class_index: head_i.entry.color_index, is_classification: 1'b0};
            if (in_range) begin
              valid_q[wr_addr] <= 1'b1;
            end
          end else if (pop_o) begin
            s_r_q   <= head_i.entry.ratio_r;
            s_g_q   <= head_i.entry.ratio_g;
            s_b_q   <= head_i.entry.ratio_b;
            base_q  <= side_base;
            cnt_q   <= '0;
            state_q <= B_SCAN;
          end
        end
        B_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST) begin
            state_q <= B_WAIT;
          end
        end
        B_WAIT: begin
          if (last) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
      if (take) begin
        best_q     <= dist_sum;
        best_tag_q <= p3_tag_q;
      end
      if (last) begin
        out_q <= '{class_index: (take ? p3_tag_q : best_tag_q), is_classification: 1'b1};
      end
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  a_store_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_go |=> out_valid_q && !out_q.is_classification)
    else $error("store item without acknowledge");

  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p3_v_q |-> state_q != B_IDLE)
    else $error("scan pipeline active while engine idle");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SCAN) |-> cnt_q <= LAST)
    else $error("scan index beyond table");

  a_class_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.is_classification) |-> $past(p3_v_q))
    else $error("classification result without scan");

endmodule

/* rtl/core/nearest_color_classifier_core.sv */
// Top level of the nearest color classifier: front end, queue, table engine, register.
//
// Items enter on item_i and are accepted at a rising edge with start high and busy low.
// A store item (mode 0) writes the chromaticity of its counts at entry color_index of
// the chosen side; a classify item (mode 1) returns the tag of the nearest entry.
// Each item yields one result on result_o, marked by result_valid_o for one cycle;
// the receiver takes it in that cycle and cannot stall.
// The front end accepts an item, runs the three ratio dividers (one quotient bit per
// cycle each) and then hands the entry off to a two-entry queue; busy stays high until
// the hand-off, which waits while the queue is full.
// The table engine writes a store entry as it pops it and, for a classify, makes one
// table read per cycle, then a three-stage distance pipeline.
// The front end can accept a new item while the table engine still works on earlier
// ones, so the slower of the two sets the sustained rate.
// After reset both tables read as zero ratios with tag 0, red_weight is 307.
// red_weight sits at APB address 0; the user must write it only while no item is in
// flight, and the block itself does not enforce this.
module nearest_color_classifier_core import ncc_pkg::*; #(
  parameter int NUM_COLORS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item_i,
  output logic        result_valid_o,
  output out_item_t   result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [WT_W-1:0] red_weight_q;
  q_push_t         push;
  q_head_t         head;
  logic            full;
  logic            pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RED_WEIGHT) ? 32'(red_weight_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_weight_q <= RED_WEIGHT_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RED_WEIGHT)) begin
      red_weight_q <= pwdata[WT_W-1:0];
    end
  end

  ncc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .item_i (item_i),
    .busy_o (busy),
    .push_o (push),
    .full_i (full)
  );

  ncc_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .full_o(full),
    .head_o(head),
    .pop_i (pop)
  );

  ncc_back #(
    .NUM_COLORS(NUM_COLORS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .red_weight_i  (red_weight_q),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

/* bench/tb_nearest_color_classifier_core.sv */
// Self-checking testbench for the nearest color classifier core.
module tb_nearest_color_classifier_core import ncc_pkg::*; ();

  localparam int NUM_COLORS = 12;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [RATIO_W-1:0] r;
    logic [RATIO_W-1:0] g;
    logic [RATIO_W-1:0] b;
  } ratio_triple_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    item_i = '0;
  logic        result_valid_o;
  out_item_t   result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nearest_color_classifier_core #(.NUM_COLORS(NUM_COLORS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .result_valid_o(result_valid_o), .result_o(result_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  ratio_triple_t   ratio_mem [2][NUM_COLORS];
  logic [TAG_W-1:0] tag_mem  [2][NUM_COLORS];
  logic [WT_W-1:0] weight_model = RED_WEIGHT_RST;
  logic [15:0]     raw_mem   [2][NUM_COLORS][3];
  out_item_t       expected_class_q[$];
  out_item_t       oldest_class;
  int              mismatch_count = 0;
  int              burst_left = 1;

  initial begin
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < NUM_COLORS; i++) begin
        ratio_mem[s][i] = '0;
        tag_mem[s][i] = '0;
        raw_mem[s][i][0] = 16'd1000;
        raw_mem[s][i][1] = 16'd1000;
        raw_mem[s][i][2] = 16'd1000;
      end
    end
  end

  task automatic note_mismatch(string what, longint unsigned exp_v, longint unsigned act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected %0d, got %0d", $time, what, exp_v, act_v);
  endtask

  // ---- predictor ----
  function automatic logic [RATIO_W-1:0] frac16(int unsigned part, int unsigned total);
    longint unsigned p;
    longint unsigned q;
    if (total == 0) return '0;
    p = part;
    q = (p << 16) / total;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic ratio_triple_t to_ratios(in_item_t it);
    int unsigned total;
    ratio_triple_t t;
    total = it.red + it.green + it.blue;
    t.r = frac16(it.red, total);
    t.g = frac16(it.green, total);
    t.b = frac16(it.blue, total);
    return t;
  endfunction

  function automatic longint unsigned sq_dist(logic [RATIO_W-1:0] a, logic [RATIO_W-1:0] b);
    longint unsigned d;
    d = (a >= b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic out_item_t predict_class(in_item_t it);
    ratio_triple_t s;
    ratio_triple_t e;
    longint unsigned best;
    longint unsigned distance;
    out_item_t r;
    int sd;
    s = to_ratios(it);
    sd = it.side;
    best = 0;
    if (it.mode == MODE_STORE) begin
      if (it.color_index < NUM_COLORS) begin
        ratio_mem[sd][it.color_index] = s;
        tag_mem[sd][it.color_index] = it.color_index;
      end
      r.class_index = it.color_index;
      r.is_classification = 1'b0;
    end else begin
      r.class_index = '0;
      for (int i = 0; i < NUM_COLORS; i++) begin
        e = ratio_mem[sd][i];
        distance = ((longint'(weight_model) * sq_dist(s.r, e.r)) >> 8)
                 + sq_dist(s.g, e.g) + sq_dist(s.b, e.b);
        if (i == 0 || distance < best) begin
          best = distance;
          r.class_index = tag_mem[sd][i];
        end
      end
      r.is_classification = 1'b1;
    end
    return r;
  endfunction

  // ---- result checker ----
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_class_q.size() == 0) begin
        note_mismatch("result with no item pending", 0, result_o);
      end else begin
        oldest_class = expected_class_q.pop_front();
        if (result_o.class_index !== oldest_class.class_index)
          note_mismatch("class_index", oldest_class.class_index, result_o.class_index);
        if (result_o.is_classification !== oldest_class.is_classification)
          note_mismatch("is_classification", oldest_class.is_classification,
                        result_o.is_classification);
      end
    end
  end

  // ---- drivers ----
  task automatic send_item(in_item_t it);
    int gap;
    item_i <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    expected_class_q.push_back(predict_class(it));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      gap = $urandom_range(1, 30);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (expected_class_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_RED_WEIGHT, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_weight_readback();
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== {{(32-WT_W){1'b0}}, weight_model})
      note_mismatch("red_weight readback", weight_model, rd);
  endtask

  task automatic set_red_weight(logic [WT_W-1:0] w);
    logic [31:0] rd;
    wait_drain();
    apb_access(1'b1, {{(32-WT_W){1'b0}}, w}, rd);
    weight_model = w;
    check_weight_readback();
  endtask

  // ---- stimulus ----
  function automatic in_item_t make_item(logic mode, logic side, logic [TAG_W-1:0] idx,
                                         logic [15:0] r, logic [15:0] g, logic [15:0] b);
    in_item_t it;
    it.mode = mode;
    it.side = side;
    it.color_index = idx;
    it.red = r;
    it.green = g;
    it.blue = b;
    return it;
  endfunction

  function automatic logic [15:0] nudge(logic [15:0] v);
    int x;
    x = int'(v);
    x = x + int'($urandom_range(0, 64)) - 32;
    if (x < 0) x = 0;
    if (x > 65535) x = 65535;
    return x[15:0];
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int style;
    int pick;
    it.mode = ($urandom_range(0, 99) < 45) ? MODE_STORE : MODE_CLASSIFY;
    it.side = 1'($urandom_range(0, 1));
    it.color_index = ($urandom_range(0, 99) < 8) ? TAG_W'($urandom_range(NUM_COLORS, 15))
                                                  : TAG_W'($urandom_range(0, NUM_COLORS - 1));
    style = $urandom_range(0, 9);
    case (style)
      0, 1, 2: begin
        it.red = 16'($urandom_range(0, 65535));
        it.green = 16'($urandom_range(0, 65535));
        it.blue = 16'($urandom_range(0, 65535));
      end
      3: begin
        it.red = 16'($urandom_range(0, 255));
        it.green = 16'($urandom_range(0, 255));
        it.blue = 16'($urandom_range(0, 255));
      end
      4: begin
        it.red = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'd0;
        it.green = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'd0;
        it.blue = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'd0;
      end
      default: begin
        pick = $urandom_range(0, NUM_COLORS - 1);
        it.red = nudge(raw_mem[it.side][pick][0]);
        it.green = nudge(raw_mem[it.side][pick][1]);
        it.blue = nudge(raw_mem[it.side][pick][2]);
      end
    endcase
    if (it.mode == MODE_STORE && it.color_index < NUM_COLORS) begin
      raw_mem[it.side][it.color_index][0] = it.red;
      raw_mem[it.side][it.color_index][1] = it.green;
      raw_mem[it.side][it.color_index][2] = it.blue;
    end
    return it;
  endfunction

  task automatic test_empty_tables();
    send_item(make_item(MODE_CLASSIFY, 1'b0, 4'd5, 16'd0, 16'd0, 16'd0));
    send_item(make_item(MODE_CLASSIFY, 1'b1, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_zero_sum_and_saturation();
    send_item(make_item(MODE_STORE, 1'b0, 4'd0, 16'd0, 16'd0, 16'd0));
    send_item(make_item(MODE_STORE, 1'b0, 4'd1, 16'hFFFF, 16'd0, 16'd0));
    send_item(make_item(MODE_STORE, 1'b0, 4'd2, 16'd0, 16'hFFFF, 16'd0));
    send_item(make_item(MODE_STORE, 1'b0, 4'd3, 16'd0, 16'd0, 16'hFFFF));
    send_item(make_item(MODE_STORE, 1'b0, 4'd11, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(MODE_CLASSIFY, 1'b0, 4'd0, 16'd1, 16'd0, 16'd0));
    send_item(make_item(MODE_CLASSIFY, 1'b0, 4'd15, 16'd0, 16'd1, 16'd0));
    send_item(make_item(MODE_CLASSIFY, 1'b0, 4'd7, 16'd0, 16'd0, 16'd1));
    send_item(make_item(MODE_CLASSIFY, 1'b0, 4'd3, 16'd0, 16'd0, 16'd0));
    send_item(make_item(MODE_CLASSIFY, 1'b0, 4'd9, 16'd7, 16'd7, 16'd7));
  endtask

  task automatic test_out_of_range_store();
    for (int i = NUM_COLORS; i < 16; i++)
      send_item(make_item(MODE_STORE, 1'b1, i[TAG_W-1:0], 16'($urandom_range(1, 65535)),
                          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))));
    send_item(make_item(MODE_CLASSIFY, 1'b1, 4'd12, 16'd500, 16'd20, 16'd9000));
  endtask

  task automatic test_tie_break();
    // same chromaticity at two entries: the lower index must win
    send_item(make_item(MODE_STORE, 1'b1, 4'd4, 16'd100, 16'd200, 16'd300));
    send_item(make_item(MODE_STORE, 1'b1, 4'd8, 16'd200, 16'd400, 16'd600));
    send_item(make_item(MODE_CLASSIFY, 1'b1, 4'd15, 16'd300, 16'd600, 16'd900));
  endtask

  task automatic test_random_items(int n);
    repeat (n) send_item(random_item());
  endtask

  task automatic test_weight_sweep();
    set_red_weight(10'd0);
    test_random_items(70);
    set_red_weight(10'd1023);
    test_random_items(70);
    set_red_weight(10'd1);
    test_random_items(70);
    set_red_weight(WT_W'($urandom_range(2, 1022)));
    test_random_items(70);
    set_red_weight(10'd512);
    test_random_items(70);
    set_red_weight(RED_WEIGHT_RST);
    test_random_items(70);
  endtask

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_weight_readback();
    test_empty_tables();
    test_zero_sum_and_saturation();
    test_out_of_range_store();
    test_tie_break();
    test_random_items(200);
    test_weight_sweep();
    wait_drain();
    if (mismatch_count == 0 && expected_class_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
